// ----- rtl/rwce_pkg.sv -----
// Shared types and constants for the release-weighted completion evaluator.
// No dependencies; every other file of the block refers to it by scoped names.
package rwce_pkg;

  localparam int MaxJobs = 63;   // highest job number held in the table
  localparam int TimeW   = 16;   // release, duration and weight width
  localparam int JobW    = 6;
  localparam int MaskW   = 64;
  localparam int PendW   = MaskW - 1;   // jobs 1..63, bit 0 of the mask dropped
  localparam int StartW  = 22;
  localparam int FinW    = 23;
  localparam int TotW    = 22;
  localparam int WtdW    = 44;
  localparam int RunCW   = 23;   // running completion register
  localparam int RunWW   = 45;   // running weighted sum register
  localparam int StW     = RunCW;        // max of release and running completion
  localparam int FinCW   = RunCW + 1;    // start plus duration before wrapping
  localparam int ProdW   = TimeW + RunCW;
  localparam int MemW    = 3 * TimeW;
  localparam int MemDepth = 1 << JobW;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_APPEND = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_TOTALS = 2'd1,
    KIND_JOB    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_CALC,
    ST_MUL,
    ST_ACC,
    ST_EMIT,
    ST_LIST_EMIT
  } state_e;

  // Which result the output register is loaded with.
  typedef enum logic [1:0] {
    RES_ACK,
    RES_APPEND,
    RES_JOB,
    RES_NONE
  } res_e;

  typedef struct packed {
    op_e                operation;
    logic [JobW-1:0]    job_index;
    logic [TimeW-1:0]   release_in;
    logic [TimeW-1:0]   duration_in;
    logic [TimeW-1:0]   weight_in;
    logic [MaskW-1:0]   done_mask;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [JobW-1:0]    job_out;
    logic [StartW-1:0]  start_time;
    logic [FinW-1:0]    finish_time;
    logic [TotW-1:0]    completion_total;
    logic [WtdW-1:0]    weighted_total;
    logic               all_done;
    logic               last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic mem_rd;    // read the job table at the current index
    logic calc_en;   // register start/finish, advance running completion
    logic mul_en;    // register weight times running completion
    logic acc_en;    // add product into running weighted sum
    logic out_ld;    // load output register
    res_e res;       // what to load
    logic adv;       // drop current pending bit, step index
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_e  in_op;
    logic in_job_ok;
    logic in_pend_none;
    op_e  op;
    logic pend_cur;
    logic last_pend;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/rwce_if.sv -----
// Valid/ready channel interfaces of the evaluator: item input, result output
// and job count configuration. Payload types come from rwce_pkg.
interface rwce_in_if;
  logic               valid;
  logic               ready;
  rwce_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface rwce_out_if;
  logic                valid;
  logic                ready;
  rwce_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface rwce_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rwce_pkg::JobW-1:0]  job_count;
  modport source (output valid, output job_count, input ready);
  modport sink   (input valid, input job_count, output ready);
endinterface

// ----- rtl/rwce_ctrl.sv -----
// Sequencing state machine of the evaluator.
// Depends on rwce_pkg; drives the datapath through dp_cmd_t, reads dp_stat_t.
module rwce_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rwce_pkg::dp_stat_t stat_i,
  output rwce_pkg::dp_cmd_t  cmd_o
);

  rwce_pkg::state_e state_q, state_d;
  rwce_pkg::res_e   res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rwce_pkg::ST_IDLE;
      res_q   <= rwce_pkg::RES_ACK;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.res  = res_q;
    unique case (state_q)
      rwce_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (stat_i.in_op)
            rwce_pkg::OP_LOAD, rwce_pkg::OP_START: begin
              res_d   = rwce_pkg::RES_ACK;
              state_d = rwce_pkg::ST_EMIT;
            end
            rwce_pkg::OP_APPEND: begin
              res_d   = rwce_pkg::RES_APPEND;
              state_d = stat_i.in_job_ok ? rwce_pkg::ST_READ : rwce_pkg::ST_EMIT;
            end
            rwce_pkg::OP_LIST: begin
              res_d   = rwce_pkg::RES_NONE;
              state_d = stat_i.in_pend_none ? rwce_pkg::ST_EMIT : rwce_pkg::ST_SCAN;
            end
            default: state_d = rwce_pkg::ST_IDLE;
          endcase
        end
      end
      rwce_pkg::ST_SCAN: begin
        if (stat_i.pend_cur) begin
          state_d = rwce_pkg::ST_READ;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      rwce_pkg::ST_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d = (stat_i.op == rwce_pkg::OP_APPEND) ? rwce_pkg::ST_CALC
                                                     : rwce_pkg::ST_LIST_EMIT;
      end
      rwce_pkg::ST_CALC: begin
        cmd_o.calc_en = 1'b1;
        state_d = rwce_pkg::ST_MUL;
      end
      rwce_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = rwce_pkg::ST_ACC;
      end
      rwce_pkg::ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d = rwce_pkg::ST_EMIT;
      end
      rwce_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d = rwce_pkg::ST_IDLE;
        end
      end
      rwce_pkg::ST_LIST_EMIT: begin
        cmd_o.res = rwce_pkg::RES_JOB;
        if (stat_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          cmd_o.adv    = 1'b1;
          state_d = stat_i.last_pend ? rwce_pkg::ST_IDLE : rwce_pkg::ST_SCAN;
        end
      end
      default: state_d = rwce_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/rwce_dpath.sv -----
// Datapath of the evaluator: job table memory, running sums, list walk
// registers and the output register. Depends on rwce_pkg.
module rwce_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rwce_pkg::in_item_t          in_item_i,
  input  logic                        cfg_valid_i,
  input  logic [rwce_pkg::JobW-1:0]   cfg_job_count_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output rwce_pkg::out_item_t         out_item_o,
  input  rwce_pkg::dp_cmd_t           cmd_i,
  output rwce_pkg::dp_stat_t          stat_o
);

  // Job table: release, duration, weight packed in one word.
  logic [rwce_pkg::MemW-1:0]  mem_q [rwce_pkg::MemDepth];
  logic [rwce_pkg::MemW-1:0]  rd_q;

  logic [rwce_pkg::JobW-1:0]  job_count_q;
  logic [rwce_pkg::RunCW-1:0] rc_q;
  logic [rwce_pkg::RunWW-1:0] rw_q;
  logic [rwce_pkg::PendW-1:0] pend_q;
  logic                       out_valid_q;
  rwce_pkg::out_item_t        out_q, out_d;

  rwce_pkg::op_e              op_q;
  logic [rwce_pkg::JobW-1:0]  idx_q;
  logic                       job_ok_q;
  logic                       done_q;
  logic [rwce_pkg::StW-1:0]   st_q;
  logic [rwce_pkg::FinCW-1:0] fin_q;
  logic [rwce_pkg::ProdW-1:0] prod_q;

  logic [rwce_pkg::JobW-1:0]  n_c;
  logic [rwce_pkg::PendW-1:0] want_c;
  logic [rwce_pkg::PendW-1:0] pend_c;
  logic                       in_job_ok_c;
  logic [rwce_pkg::JobW-1:0]  sel_c;
  logic [rwce_pkg::TimeW-1:0] rel_c, dur_c, wgt_c;
  logic [rwce_pkg::StW-1:0]   st_c;
  logic [rwce_pkg::FinCW-1:0] fin_c;

  assign n_c = (job_count_q > rwce_pkg::JobW'(rwce_pkg::MaxJobs))
             ? rwce_pkg::JobW'(rwce_pkg::MaxJobs) : job_count_q;

  always_comb begin
    for (int i = 0; i < rwce_pkg::PendW; i++) begin
      want_c[i] = (rwce_pkg::JobW'(i + 1) <= n_c);
    end
  end

  assign pend_c = ~in_item_i.done_mask[rwce_pkg::MaskW-1:1] & want_c;
  assign in_job_ok_c = (in_item_i.job_index != '0) &&
                       (in_item_i.job_index <= rwce_pkg::JobW'(rwce_pkg::MaxJobs));

  assign sel_c = idx_q - rwce_pkg::JobW'(1);

  assign rel_c = rd_q[3*rwce_pkg::TimeW-1 -: rwce_pkg::TimeW];
  assign dur_c = rd_q[2*rwce_pkg::TimeW-1 -: rwce_pkg::TimeW];
  assign wgt_c = rd_q[rwce_pkg::TimeW-1:0];
  assign st_c  = (rwce_pkg::StW'(rel_c) > rc_q) ? rwce_pkg::StW'(rel_c) : rc_q;
  assign fin_c = rwce_pkg::FinCW'(st_c) + rwce_pkg::FinCW'(dur_c);

  // Table write on a load beat; registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_item_i.operation == rwce_pkg::OP_LOAD && in_job_ok_c) begin
      mem_q[in_item_i.job_index] <= {in_item_i.release_in, in_item_i.duration_in,
                                     in_item_i.weight_in};
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_count_q <= rwce_pkg::JobW'(1);
      rc_q        <= '0;
      rw_q        <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        job_count_q <= cfg_job_count_i;
      end
      if (cmd_i.accept && in_item_i.operation == rwce_pkg::OP_START) begin
        rc_q <= '0;
        rw_q <= '0;
      end
      if (cmd_i.calc_en) begin
        rc_q <= fin_c[rwce_pkg::RunCW-1:0];
      end
      if (cmd_i.acc_en) begin
        rw_q <= rw_q + rwce_pkg::RunWW'(prod_q);
      end
      if (cmd_i.accept) begin
        pend_q <= pend_c;
      end else if (cmd_i.adv) begin
        pend_q[sel_c] <= 1'b0;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= in_item_i.operation;
      idx_q    <= (in_item_i.operation == rwce_pkg::OP_LIST) ? rwce_pkg::JobW'(1)
                                                             : in_item_i.job_index;
      job_ok_q <= in_job_ok_c;
      done_q   <= (in_item_i.done_mask[rwce_pkg::MaskW-1:1] == want_c);
    end else if (cmd_i.adv) begin
      idx_q <= idx_q + rwce_pkg::JobW'(1);
    end
    if (cmd_i.calc_en) begin
      st_q  <= st_c;
      fin_q <= fin_c;
    end
    if (cmd_i.mul_en) begin
      prod_q <= rwce_pkg::ProdW'(wgt_c) * rwce_pkg::ProdW'(rc_q);
    end
    if (cmd_i.out_ld) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    out_d = '0;
    out_d.completion_total = rc_q[rwce_pkg::TotW-1:0];
    out_d.weighted_total   = rw_q[rwce_pkg::WtdW-1:0];
    out_d.last             = 1'b1;
    unique case (cmd_i.res)
      rwce_pkg::RES_ACK: begin
        out_d.kind             = rwce_pkg::KIND_ACK;
        out_d.job_out          = (op_q == rwce_pkg::OP_LOAD) ? idx_q : '0;
        out_d.completion_total = '0;
        out_d.weighted_total   = '0;
      end
      rwce_pkg::RES_APPEND: begin
        out_d.kind = rwce_pkg::KIND_TOTALS;
        if (job_ok_q) begin
          out_d.job_out     = idx_q;
          out_d.start_time  = st_q[rwce_pkg::StartW-1:0];
          out_d.finish_time = fin_q[rwce_pkg::FinW-1:0];
        end
      end
      rwce_pkg::RES_JOB: begin
        out_d.kind        = rwce_pkg::KIND_JOB;
        out_d.job_out     = idx_q;
        out_d.start_time  = st_c[rwce_pkg::StartW-1:0];
        out_d.finish_time = fin_c[rwce_pkg::FinW-1:0];
        out_d.all_done    = done_q;
        out_d.last        = stat_o.last_pend;
      end
      rwce_pkg::RES_NONE: begin
        out_d.kind     = rwce_pkg::KIND_NONE;
        out_d.all_done = done_q;
      end
      default: out_d = '0;
    endcase
  end

  assign stat_o.in_op        = in_item_i.operation;
  assign stat_o.in_job_ok    = in_job_ok_c;
  assign stat_o.in_pend_none = (pend_c == '0);
  assign stat_o.op           = op_q;
  assign stat_o.pend_cur     = pend_q[sel_c];
  assign stat_o.last_pend    = ((pend_q & ~(rwce_pkg::PendW'(1) << sel_c)) == '0);
  assign stat_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- rtl/release_weighted_completion_eval_core.sv -----
// Single-machine schedule evaluator with release times and weighted completion.
// Load fills a 64-entry job table (release, duration, weight; job 1..63), start
// clears the running sums, append schedules one job at the later of its release
// and the running completion and adds weight times its finish to the weighted
// sum, and list reports every job 1..job_count not set in done_mask with its
// earliest start and finish, flagging all_done when the mask covers exactly
// those jobs. One item is worked at a time. Load and start go from the accept
// step straight to the output step; append steps through accept, table read,
// max and add, 16x23 multiply, accumulate and output. List checks and steps
// over each job before the last reported one, and takes each job it reports
// through check, table read and output, since every reported job uses the single
// table read port; a list with nothing pending goes straight to output.
// The output register holds a finished result while the next item is accepted;
// a stalled output stalls only the step that needs to write it. Table entries
// read before being loaded return unspecified values. job_count may be written
// on the configuration channel only while no item is in flight; reset value 1.
// Depends on rwce_pkg, rwce_if, rwce_ctrl and rwce_dpath.
module release_weighted_completion_eval_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  rwce_in_if.sink     in_i,
  rwce_out_if.source  out_o,
  rwce_cfg_if.sink    cfg_i
);

  rwce_pkg::dp_cmd_t  cmd;
  rwce_pkg::dp_stat_t stat;

  // Configuration beats are always taken.
  assign cfg_i.ready = 1'b1;

  // Sequence one item at a time.
  rwce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold the table, the sums and the output register.
  rwce_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_item_i       (in_i.item),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_job_count_i (cfg_i.job_count),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_item_o      (out_o.item),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule
